// File: src/affine_2d_matrix_stack_unit_defines.svh
// Assertion macros for the affine matrix stack unit.
`ifndef AFFINE_2D_MATRIX_STACK_UNIT_DEFINES_SVH
`define AFFINE_2D_MATRIX_STACK_UNIT_DEFINES_SVH
// Check that a condition implies a consequence on the next cycle.
`define AMS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define AMS_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
`endif

// File: src/ams_pkg.sv
// Types, constants and helper functions of the affine matrix stack unit.
package ams_pkg;
	localparam int STACK_DEPTH = 16;
	localparam int FRACTION_BITS = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH * 6);
	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam int ANG_FRAC = 24;
	localparam int VEC_FRAC = 30;
	localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
	localparam logic signed [33:0] RADIAN_UNITS = 34'sd961263669;
	localparam logic signed [34:0] FULL_TURN = 35'sd360 <<< ANG_FRAC;
	localparam logic signed [34:0] HALF_TURN = 35'sd180 <<< ANG_FRAC;
	localparam logic signed [34:0] QUARTER_TURN = 35'sd90 <<< ANG_FRAC;

	typedef enum logic [2:0] {
		CMD_IDENTITY = 3'd0, CMD_PUSH = 3'd1, CMD_POP = 3'd2, CMD_TRANSLATE = 3'd3,
		CMD_ROTATE = 3'd4, CMD_SCALE = 3'd5, CMD_VERTEX = 3'd6, CMD_NONE = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2, ST_SPARE = 2'd3
	} status_t;

	function automatic logic signed [33:0] atan_units(input logic [STEP_W-1:0] i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sd754974720;
			1: r = 34'sd445687602;
			2: r = 34'sd235489088;
			3: r = 34'sd119537938;
			4: r = 34'sd60000934;
			5: r = 34'sd30029717;
			6: r = 34'sd15018523;
			7: r = 34'sd7509720;
			8: r = 34'sd3754917;
			9: r = 34'sd1877466;
			default: r = (RADIAN_UNITS + (34'sd1 <<< (i - 1))) >>> i;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'h7fffffff;
		if (v < -66'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction
endpackage

// File: src/ams_ram.sv
// Generic single-port RAM with registered read.
module ams_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// File: src/ams_cordic.sv
// Iterative CORDIC producing cosine and sine of an angle in degrees.
module ams_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [25:0]  angle,
	output logic                done,
	output logic signed [31:0]  cs,
	output logic signed [31:0]  sn
);
	import ams_pkg::*;
	logic signed [34:0] z_q, zr;
	logic signed [33:0] x_q, y_q, xr, yr;
	logic neg_q, busy_q;
	logic [STEP_W-1:0] step_q;
	always_comb begin
		zr = 35'(angle) <<< (ANG_FRAC - FRACTION_BITS);
		if (zr >= FULL_TURN) zr = zr - FULL_TURN;
		else if (zr <= -FULL_TURN) zr = zr + FULL_TURN;
		if (zr < 0) zr = zr + FULL_TURN;
		if (zr >= HALF_TURN) zr = zr - FULL_TURN;
		xr = (x_q + (34'sd1 <<< (VEC_FRAC - FRACTION_BITS - 1))) >>> (VEC_FRAC - FRACTION_BITS);
		yr = (y_q + (34'sd1 <<< (VEC_FRAC - FRACTION_BITS - 1))) >>> (VEC_FRAC - FRACTION_BITS);
	end
	assign cs = neg_q ? -xr[31:0] : xr[31:0];
	assign sn = neg_q ? -yr[31:0] : yr[31:0];
	assign done = busy_q && step_q == STEP_W'(CORDIC_STEPS);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= INV_GAIN;
			y_q <= '0;
			if (zr > QUARTER_TURN) begin
				z_q <= zr - HALF_TURN;
				neg_q <= 1'b1;
			end else if (zr < -QUARTER_TURN) begin
				z_q <= zr + HALF_TURN;
				neg_q <= 1'b1;
			end else begin
				z_q <= zr;
				neg_q <= 1'b0;
			end
		end else if (busy_q && !done) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> step_q);
				y_q <= y_q + (x_q >>> step_q);
				z_q <= z_q - 35'(atan_units(step_q));
			end else begin
				x_q <= x_q + (y_q >>> step_q);
				y_q <= y_q - (x_q >>> step_q);
				z_q <= z_q + 35'(atan_units(step_q));
			end
		end
	end
endmodule

// File: src/affine_2d_matrix_stack_unit.sv
// Top level of the affine matrix stack unit.
// Usage:
//  One input beat carries a command and its operands; one result beat answers it.
//  Commands: identity, push, pop, translate, rotate, scale, vertex.
//  The block takes one command at a time. in_stall is high while a command is
//  in flight or its result waits in the output register.
//  Identity, unused codes, push when full and pop when empty go straight to the
//  result beat. Translate and vertex take two multiply-add steps through the
//  shared multiplier pair; scale takes four steps; push and pop copy six words
//  through the single stack RAM port; rotate runs the CORDIC iterations, then
//  four steps.
//  The next command can be taken in the cycle after the result beat is accepted.
//  The current matrix sits in a six-word register file; saved matrices sit in
//  the stack RAM, one word per cycle.
//  Reset loads the identity and empties the stack; the RAM is not cleared since
//  only pushed entries are ever read.
//  When out_stall is high the result beat holds and no new command is taken.
module affine_2d_matrix_stack_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic signed [31:0]  shift_x,
	input  logic signed [31:0]  shift_y,
	input  logic signed [25:0]  angle_degrees,
	input  logic signed [31:0]  factor_x,
	input  logic signed [31:0]  factor_y,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic                has_point,
	output logic signed [31:0]  result_x,
	output logic signed [31:0]  result_y,
	output logic signed [15:0]  rounded_x,
	output logic signed [15:0]  rounded_y
);
	import ams_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_CORDIC = 6'b000010, S_MUL = 6'b000100,
		S_COPY = 6'b001000, S_DONE = 6'b010000, S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic signed [31:0] a_q, b_q, cs_q, sn_q;
	logic signed [31:0] m_q [6];
	logic signed [31:0] nm_q [6];
	logic [LEVEL_W-1:0] level_q;
	logic [2:0] idx_q;
	logic [3:0] cnt_q;
	logic signed [63:0] p0_q, p1_q;
	logic [1:0] status_q;
	logic cordic_start, cordic_done;
	logic signed [31:0] cordic_cs, cordic_sn;
	logic ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [31:0] ram_rdata;
	logic signed [31:0] mul_a0, mul_b0, mul_a1, mul_b1, mul_add;
	logic signed [31:0] fx;
	logic [FRACTION_BITS+1:0] lo;
	logic signed [65:0] hi;
	logic [LEVEL_W-1:0] base_lvl;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign cordic_start = accept && command == CMD_ROTATE;

	ams_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start), .angle(angle_degrees),
		.done(cordic_done), .cs(cordic_cs), .sn(cordic_sn)
	);

	assign base_lvl = (cmd_q == CMD_POP) ? level_q - 1'b1 : level_q;
	assign ram_addr = ADDR_W'(base_lvl * 6 + idx_q);
	assign ram_we = state_q == S_COPY && cmd_q == CMD_PUSH && cnt_q < 4'd6;

	ams_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH * 6)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(m_q[idx_q]), .rdata(ram_rdata)
	);

	// operand selection for the output word idx_q
	always_comb begin
		mul_a0 = '0; mul_b0 = '0; mul_a1 = '0; mul_b1 = '0; mul_add = '0;
		case (cmd_q)
			CMD_TRANSLATE, CMD_VERTEX: begin
				mul_a0 = a_q; mul_a1 = b_q;
				mul_b0 = (idx_q < 3'd3) ? m_q[0] : m_q[3];
				mul_b1 = (idx_q < 3'd3) ? m_q[1] : m_q[4];
				mul_add = (idx_q < 3'd3) ? m_q[2] : m_q[5];
			end
			CMD_SCALE: begin
				mul_a0 = (idx_q == 3'd0 || idx_q == 3'd3) ? a_q : b_q;
				mul_b0 = m_q[idx_q];
			end
			CMD_ROTATE: begin
				case (idx_q)
					3'd0: begin mul_a0 = m_q[0]; mul_b0 = cs_q; mul_a1 = m_q[1]; mul_b1 = sn_q; end
					3'd1: begin mul_a0 = m_q[1]; mul_b0 = cs_q; mul_a1 = m_q[0]; mul_b1 = -sn_q; end
					3'd3: begin mul_a0 = m_q[3]; mul_b0 = cs_q; mul_a1 = m_q[4]; mul_b1 = sn_q; end
					default: begin mul_a0 = m_q[4]; mul_b0 = cs_q; mul_a1 = m_q[3]; mul_b1 = -sn_q; end
				endcase
			end
			default: ;
		endcase
	end

	// round half up and saturate the registered products
	always_comb begin
		lo = {2'b0, p0_q[FRACTION_BITS-1:0]} + {2'b0, p1_q[FRACTION_BITS-1:0]}
			+ (FRACTION_BITS+2)'(1 << (FRACTION_BITS - 1));
		hi = 66'(p0_q >>> FRACTION_BITS) + 66'(p1_q >>> FRACTION_BITS)
			+ 66'(lo >> FRACTION_BITS) + 66'(mul_add);
		fx = sat32(hi);
	end

	function automatic logic signed [15:0] round16(input logic signed [31:0] v);
		logic signed [32:0] r, t;
		r = 33'(v) + (33'sd1 <<< (FRACTION_BITS - 1));
		t = (r >= 0) ? (r >>> FRACTION_BITS) : -((-r) >>> FRACTION_BITS);
		if (t > 33'sd32767) return 16'sh7fff;
		if (t < -33'sd32768) return 16'sh8000;
		return t[15:0];
	endfunction

	// the multiply-add engine walks a step list: translate 2, scale 4, rotate 4, vertex 2
	function automatic logic [2:0] next_idx(input cmd_t c, input logic [2:0] i);
		logic [2:0] r;
		case (c)
			CMD_TRANSLATE, CMD_VERTEX: r = (i == 3'd2) ? 3'd5 : 3'd7;
			default: r = (i == 3'd0) ? 3'd1 : (i == 3'd1) ? 3'd3 : (i == 3'd3) ? 3'd4 : 3'd7;
		endcase
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			level_q <= '0;
			for (int k = 0; k < 6; k++)
				m_q[k] <= (k == 0 || k == 4) ? 32'sd1 <<< FRACTION_BITS : '0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (accept) begin
					cmd_q <= cmd_t'(command);
					has_point <= 1'b0;
					result_x <= '0; result_y <= '0; rounded_x <= '0; rounded_y <= '0;
					cnt_q <= '0;
					for (int k = 0; k < 6; k++) nm_q[k] <= m_q[k];
					case (cmd_t'(command))
						CMD_IDENTITY: begin
							for (int k = 0; k < 6; k++)
								m_q[k] <= (k == 0 || k == 4) ? 32'sd1 <<< FRACTION_BITS : '0;
							level_q <= '0;
							status_q <= ST_OK;
							state_q <= S_OUT;
						end
						CMD_PUSH: begin
							idx_q <= '0;
							if (level_q >= LEVEL_W'(STACK_DEPTH)) begin
								status_q <= ST_FULL; state_q <= S_OUT;
							end else begin
								status_q <= ST_OK; state_q <= S_COPY;
							end
						end
						CMD_POP: begin
							idx_q <= '0;
							if (level_q == '0) begin
								status_q <= ST_EMPTY; state_q <= S_OUT;
							end else begin
								status_q <= ST_OK; state_q <= S_COPY;
							end
						end
						CMD_TRANSLATE: begin
							a_q <= shift_x; b_q <= shift_y; idx_q <= 3'd2; state_q <= S_MUL;
							status_q <= ST_OK;
						end
						CMD_SCALE: begin
							a_q <= factor_x; b_q <= factor_y; idx_q <= 3'd0; state_q <= S_MUL;
							status_q <= ST_OK;
						end
						CMD_VERTEX: begin
							a_q <= point_x; b_q <= point_y; idx_q <= 3'd2; state_q <= S_MUL;
							status_q <= ST_OK;
						end
						CMD_ROTATE: begin
							idx_q <= 3'd0; state_q <= S_CORDIC;
							status_q <= ST_OK;
						end
						default: begin
							status_q <= ST_OK; state_q <= S_OUT;
						end
					endcase
				end
				S_CORDIC: if (cordic_done) begin
					cs_q <= cordic_cs; sn_q <= cordic_sn; state_q <= S_MUL;
				end
				S_MUL: begin
					// cnt 0: multiply, cnt 1: round and store
					if (cnt_q == '0) begin
						p0_q <= mul_a0 * mul_b0;
						p1_q <= mul_a1 * mul_b1;
						cnt_q <= 4'd1;
					end else begin
						nm_q[idx_q] <= fx;
						cnt_q <= '0;
						if (next_idx(cmd_q, idx_q) == 3'd7) state_q <= S_DONE;
						else idx_q <= next_idx(cmd_q, idx_q);
					end
				end
				S_COPY: begin
					// push writes one word a cycle; pop reads through the registered RAM output
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q < 4'd5) idx_q <= idx_q + 1'b1;
					if (cmd_q == CMD_POP && cnt_q != '0) m_q[3'(cnt_q - 1'b1)] <= ram_rdata;
					if (cnt_q == 4'd6) begin
						level_q <= (cmd_q == CMD_PUSH) ? level_q + 1'b1 : level_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_DONE: begin
					if (cmd_q == CMD_VERTEX) begin
						has_point <= 1'b1;
						result_x <= nm_q[2]; result_y <= nm_q[5];
						rounded_x <= round16(nm_q[2]); rounded_y <= round16(nm_q[5]);
					end else begin
						for (int k = 0; k < 6; k++) m_q[k] <= nm_q[k];
					end
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status = status_q;
endmodule

// File: src/ams_checker.sv
// Port-level checker for the affine matrix stack unit, bound to the top level.
`include "affine_2d_matrix_stack_unit_defines.svh"
module ams_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        has_point,
	input logic [31:0] result_x
);
	`AMS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && !in_stall, in_stall)
	`AMS_ASSERT_NOW(a_busy_while_out, clk, arst_n, out_valid, in_stall)
	`AMS_ASSERT_NOW(a_point_ok, clk, arst_n, out_valid && has_point, status == 2'd0)
	`AMS_ASSERT_NOW(a_no_point_zero, clk, arst_n, out_valid && !has_point, result_x == 32'd0)
	`AMS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status))
endmodule

bind affine_2d_matrix_stack_unit ams_checker u_ams_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.has_point(has_point), .result_x(result_x)
);

// File: verif/tb_affine_2d_matrix_stack_unit.sv
// Testbench for the affine matrix stack unit: predicts each command's result and checks every beat.
`timescale 1ns / 100ps

import ams_pkg::*;

typedef struct {
	cmd_t               cmd;
	int                 sx, sy;
	logic signed [25:0] ang;
	int                 fx, fy, px, py;
} command_beat_t;

typedef struct {
	logic [1:0]         status;
	logic               has_point;
	logic signed [31:0] rx, ry;
	logic signed [15:0] qx, qy;
} transform_result_t;

class matrix_stack_scoreboard;
	int                mat[6];
	int                saved[STACK_DEPTH * 6];
	int                level;
	transform_result_t pending_results[$];
	int                errors;
	longint            atan_head[10] = '{754974720, 445687602, 235489088, 119537938, 60000934,
		30029717, 15018523, 7509720, 3754917, 1877466};

	function void load_identity();
		foreach (mat[i]) mat[i] = 0;
		mat[0] = 1 << FRACTION_BITS;
		mat[4] = 1 << FRACTION_BITS;
		level = 0;
	endfunction

	function int fixed_sum(longint p, longint q, longint add);
		logic signed [65:0] s;
		s = p;
		s = s + q + (66'sd1 <<< (FRACTION_BITS - 1));
		s = (s >>> FRACTION_BITS) + add;
		if (s > 66'sd2147483647) return 32'h7fffffff;
		if (s < -66'sd2147483648) return 32'h80000000;
		return int'(s[31:0]);
	endfunction

	function longint arc_step(int i);
		if (i < 10) return atan_head[i];
		return (longint'(961263669) + (longint'(1) << (i - 1))) >>> i;
	endfunction

	function void sine_cosine(longint a, output longint cs, output longint sn);
		longint z, x, y, dx, dy, full, half, quarter;
		bit flip;
		full = longint'(360) << ANG_FRAC;
		half = longint'(180) << ANG_FRAC;
		quarter = longint'(90) << ANG_FRAC;
		flip = 0;
		x = 652032874;
		y = 0;
		z = a * (longint'(1) << (ANG_FRAC - FRACTION_BITS));
		z = z % full;
		if (z < 0) z += full;
		if (z >= half) z -= full;
		if (z > quarter) begin
			z -= half;
			flip = 1;
		end else if (z < -quarter) begin
			z += half;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step(i);
			end else begin
				x += dx; y -= dy; z += arc_step(i);
			end
		end
		x = (x + (longint'(1) << (VEC_FRAC - FRACTION_BITS - 1))) >>> (VEC_FRAC - FRACTION_BITS);
		y = (y + (longint'(1) << (VEC_FRAC - FRACTION_BITS - 1))) >>> (VEC_FRAC - FRACTION_BITS);
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endfunction

	function logic signed [15:0] round_int(int v);
		longint r, t;
		r = longint'(v) + (longint'(1) << (FRACTION_BITS - 1));
		t = (r >= 0) ? (r >>> FRACTION_BITS) : -((-r) >>> FRACTION_BITS);
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[15:0];
	endfunction

	function new();
		errors = 0;
		foreach (saved[i]) saved[i] = 0;
		load_identity();
	endfunction

	function void note_command(command_beat_t b);
		transform_result_t e;
		longint cs, sn, t0, t1, t3, t4;
		e = '{ST_OK, 1'b0, 0, 0, 0, 0};
		case (b.cmd)
			CMD_IDENTITY: load_identity();
			CMD_PUSH: begin
				if (level >= STACK_DEPTH) e.status = ST_FULL;
				else begin
					for (int i = 0; i < 6; i++) saved[level * 6 + i] = mat[i];
					level++;
				end
			end
			CMD_POP: begin
				if (level == 0) e.status = ST_EMPTY;
				else begin
					level--;
					for (int i = 0; i < 6; i++) mat[i] = saved[level * 6 + i];
				end
			end
			CMD_TRANSLATE: begin
				mat[2] = fixed_sum(longint'(b.sx) * mat[0], longint'(b.sy) * mat[1], mat[2]);
				mat[5] = fixed_sum(longint'(b.sx) * mat[3], longint'(b.sy) * mat[4], mat[5]);
			end
			CMD_ROTATE: begin
				t0 = mat[0]; t1 = mat[1]; t3 = mat[3]; t4 = mat[4];
				sine_cosine(longint'(b.ang), cs, sn);
				mat[0] = fixed_sum(t0 * cs, t1 * sn, 0);
				mat[1] = fixed_sum(t1 * cs, -(t0 * sn), 0);
				mat[3] = fixed_sum(t3 * cs, t4 * sn, 0);
				mat[4] = fixed_sum(t4 * cs, -(t3 * sn), 0);
			end
			CMD_SCALE: begin
				mat[0] = fixed_sum(longint'(b.fx) * mat[0], 0, 0);
				mat[3] = fixed_sum(longint'(b.fx) * mat[3], 0, 0);
				mat[1] = fixed_sum(longint'(b.fy) * mat[1], 0, 0);
				mat[4] = fixed_sum(longint'(b.fy) * mat[4], 0, 0);
			end
			CMD_VERTEX: begin
				e.has_point = 1'b1;
				e.rx = fixed_sum(longint'(b.px) * mat[0], longint'(b.py) * mat[1], mat[2]);
				e.ry = fixed_sum(longint'(b.px) * mat[3], longint'(b.py) * mat[4], mat[5]);
				e.qx = round_int(e.rx);
				e.qy = round_int(e.ry);
			end
			default: ;
		endcase
		pending_results.push_back(e);
	endfunction

	function void check_result(transform_result_t a);
		transform_result_t e;
		if (pending_results.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result beat at %0t", $realtime);
			return;
		end
		e = pending_results.pop_front();
		if (a !== e) begin
			errors++;
			if (errors <= 10)
				$display("mismatch at %0t: exp st=%0d pt=%0d x=%0d y=%0d qx=%0d qy=%0d, got st=%0d pt=%0d x=%0d y=%0d qx=%0d qy=%0d",
					$realtime, e.status, e.has_point, e.rx, e.ry, e.qx, e.qy,
					a.status, a.has_point, a.rx, a.ry, a.qx, a.qy);
		end
	endfunction
endclass

module tb_affine_2d_matrix_stack_unit;
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         command;
	logic signed [31:0] shift_x, shift_y, factor_x, factor_y, point_x, point_y;
	logic signed [25:0] angle_degrees;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic               has_point;
	logic signed [31:0] result_x, result_y;
	logic signed [15:0] rounded_x, rounded_y;

	matrix_stack_scoreboard sb = new();
	int  cycles = 0;
	int  hold_cycles = 0;
	bit  quiet = 0;
	int  stall_left = 0;
	localparam int CYCLE_LIMIT = 500000;

	affine_2d_matrix_stack_unit dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{status, has_point, result_x, result_y, rounded_x, rounded_y});

	function int idle_draw();
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// receiver: random stall after each beat, plus the long hold when asked
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall) begin
				stall_left = idle_draw();
				out_stall <= (stall_left != 0);
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= (stall_left != 0);
			end else
				out_stall <= 1'b0;
		end
	end

	function int rand_q();
		case ($urandom_range(0, 9))
			6, 7: return $urandom;
			8: return 32'h7fffffff;
			9: return 32'h80000000;
			default: return int'($urandom_range(0, 32'h80000)) - 32'h40000;
		endcase
	endfunction

	function int rand_factor();
		int f;
		if ($urandom_range(0, 9) > 6) return rand_q();
		f = $urandom_range(32768, 131072);
		return $urandom_range(0, 1) ? -f : f;
	endfunction

	function command_beat_t random_beat(cmd_t c);
		command_beat_t b;
		int a;
		a = int'($urandom_range(0, 47185920)) - 23592960;
		b.cmd = c;
		b.sx = rand_q(); b.sy = rand_q();
		b.ang = a[25:0];
		b.fx = rand_factor(); b.fy = rand_factor();
		b.px = rand_q(); b.py = rand_q();
		return b;
	endfunction

	task send_beat(command_beat_t b);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= b.cmd;
		shift_x       <= b.sx;
		shift_y       <= b.sy;
		angle_degrees <= b.ang;
		factor_x      <= b.fx;
		factor_y      <= b.fy;
		point_x       <= b.px;
		point_y       <= b.py;
		do @(posedge clk); while (in_stall);
		sb.note_command(b);
	endtask

	task send_cmd(cmd_t c);
		send_beat(random_beat(c));
	endtask

	task send_rotate(int deg_q);
		command_beat_t b;
		b = random_beat(CMD_ROTATE);
		b.ang = deg_q[25:0];
		send_beat(b);
	endtask

	task send_vertex(int x, int y);
		command_beat_t b;
		b = random_beat(CMD_VERTEX);
		b.px = x; b.py = y;
		send_beat(b);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	function cmd_t pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return CMD_IDENTITY;
		if (r < 22) return CMD_PUSH;
		if (r < 38) return CMD_POP;
		if (r < 50) return CMD_TRANSLATE;
		if (r < 62) return CMD_ROTATE;
		if (r < 72) return CMD_SCALE;
		if (r < 97) return CMD_VERTEX;
		return CMD_NONE;
	endfunction

	initial begin
		command_beat_t b;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		command       = CMD_IDENTITY;
		shift_x       = 0;
		shift_y       = 0;
		angle_degrees = 0;
		factor_x      = 0;
		factor_y      = 0;
		point_x       = 0;
		point_y       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, rounding edges, angle folds, stack limits
		send_vertex(32'h7fffffff, 32'h80000000);
		send_vertex(-32768, 32768);
		send_vertex(-98304, 32767);
		send_cmd(CMD_NONE);
		send_cmd(CMD_POP);
		b = random_beat(CMD_TRANSLATE);
		b.sx = 32'h7fffffff; b.sy = 32'h80000000;
		send_beat(b);
		send_vertex(65536, 65536);
		send_cmd(CMD_IDENTITY);
		b = random_beat(CMD_SCALE);
		b.fx = 32'h80000000; b.fy = 32'h7fffffff;
		send_beat(b);
		send_vertex(65536, -65536);
		send_cmd(CMD_IDENTITY);
		send_rotate(0);
		send_rotate(90 << 16);
		send_rotate(-(90 << 16));
		send_rotate(180 << 16);
		send_rotate(23592960);
		send_rotate(-23592960);
		send_rotate(45 << 16);
		send_vertex(10 << 16, 3 << 16);
		for (int i = 0; i <= STACK_DEPTH; i++) send_cmd(CMD_PUSH);
		for (int i = 0; i <= STACK_DEPTH; i++) send_cmd(CMD_POP);

		for (int n = 0; n < 950; n++) begin
			if (n == 300) hold_cycles = 400;
			if (n == 450) quiet = 1;
			if (n == 550) quiet = 0;
			if (n == 700) drain();
			send_cmd(pick_cmd());
		end
		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
